FILE: rtl/klvl_pkg.sv
package klvl_pkg;

    localparam int OFS_W = 48;
    localparam int LEN_W = 64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } klvl_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] essence_offset;
        logic [LEN_W-1:0] essence_length;
    } klvl_out_t;

    // Result status codes.
    localparam logic [1:0] STATUS_FOUND    = 2'd0;
    localparam logic [1:0] STATUS_EOS      = 2'd1;
    localparam logic [1:0] STATUS_PARTITION = 2'd2;
    localparam logic [1:0] STATUS_BER_LONG = 2'd3;

    typedef enum logic [1:0] {
        FS_KEY,
        FS_LEN0,
        FS_LENN,
        FS_SKIP
    } klvl_field_t;

    // Bit positions in the key match flags.
    localparam int FLAG_BODY = 0;
    localparam int FLAG_ESS  = 1;
    localparam int FLAG_PART = 2;

    localparam logic [3:0] KEY_LAST_IDX   = 4'd15;
    localparam logic [3:0] ESS_PREFIX_LEN = 4'd8;
    localparam logic [3:0] PART_PREFIX_LEN = 4'd13;
    localparam logic [6:0] BER_MAX_BYTES  = 7'd8;

    localparam logic [7:0] BODY_KEY [16] = '{
        8'h06, 8'h0e, 8'h2b, 8'h34, 8'h02, 8'h05, 8'h01, 8'h01,
        8'h0d, 8'h01, 8'h02, 8'h01, 8'h01, 8'h03, 8'h04, 8'h00 };

    // Only the first ESS_PREFIX_LEN entries are compared; the rest are padding.
    localparam logic [7:0] ESS_PREFIX [16] = '{
        8'h06, 8'h0e, 8'h2b, 8'h34, 8'h01, 8'h02, 8'h01, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00 };

    // Only the first PART_PREFIX_LEN entries are compared; the rest are padding.
    localparam logic [7:0] PART_PREFIX [16] = '{
        8'h06, 8'h0e, 8'h2b, 8'h34, 8'h02, 8'h05, 8'h01, 8'h01,
        8'h0d, 8'h01, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00 };

    typedef struct packed {
        logic             search_phase;
        klvl_field_t      field_state;
        logic [3:0]       key_byte_index;
        logic [2:0]       key_match_flags;
        logic [3:0]       ber_bytes_left;
        logic [LEN_W-1:0] length_accumulator;
        logic [LEN_W-1:0] skip_remaining;
        logic             reported_flag;
    } klvl_state_t;

    localparam klvl_state_t STATE_RESET = '{
        search_phase:       1'b0,
        field_state:        FS_KEY,
        key_byte_index:     4'd0,
        key_match_flags:    3'b111,
        ber_bytes_left:     4'd0,
        length_accumulator: '0,
        skip_remaining:     '0,
        reported_flag:      1'b0
    };

endpackage

FILE: rtl/klvl_step.sv
module klvl_step
    import klvl_pkg::*;
#(
    parameter int OFFSET_BITS = 48
)
(
    input  klvl_state_t            cur,
    input  logic [OFFSET_BITS-1:0] cur_pos,
    input  klvl_in_t               in_word,
    output klvl_state_t            nxt,
    output logic [OFFSET_BITS-1:0] nxt_pos,
    output logic                   res_valid,
    output klvl_out_t              res_word
);

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [63:0]            pos_wide;
    logic [LEN_W-1:0]       acc_shift;
    logic [LEN_W-1:0]       len_sel;
    logic                   len_fire;
    logic [3:0]             ber_left_dec;
    logic [LEN_W-1:0]       skip_dec;
    logic [7:0]             b;
    logic [3:0]             idx;

    assign b         = in_word.data_byte;
    assign idx       = cur.key_byte_index;
    assign pos_inc   = cur_pos + 1'b1;
    assign pos_wide  = 64'(pos_inc);
    assign acc_shift = {cur.length_accumulator[LEN_W-9:0], b};
    assign ber_left_dec = (cur.ber_bytes_left != 4'd0) ? cur.ber_bytes_left - 4'd1
                                                       : cur.ber_bytes_left;
    assign skip_dec  = (cur.skip_remaining != '0) ? cur.skip_remaining - 1'b1
                                                  : cur.skip_remaining;

    always_comb
    begin
        nxt       = cur;
        nxt_pos   = cur_pos;
        res_valid = 1'b0;
        res_word  = '0;
        len_sel   = '0;
        len_fire  = 1'b0;

        if (!cur.reported_flag)
        begin
            unique case (cur.field_state)
                FS_KEY:
                begin
                    if (b != BODY_KEY[idx])
                        nxt.key_match_flags[FLAG_BODY] = 1'b0;
                    if (idx < ESS_PREFIX_LEN && b != ESS_PREFIX[idx])
                        nxt.key_match_flags[FLAG_ESS] = 1'b0;
                    if (idx < PART_PREFIX_LEN && b != PART_PREFIX[idx])
                        nxt.key_match_flags[FLAG_PART] = 1'b0;
                    if (idx == KEY_LAST_IDX)
                    begin
                        nxt.key_byte_index = 4'd0;
                        nxt.field_state    = FS_LEN0;
                    end
                    else
                    begin
                        nxt.key_byte_index = idx + 4'd1;
                    end
                end
                FS_LEN0:
                begin
                    if (!b[7])
                    begin
                        len_fire = 1'b1;
                        len_sel  = LEN_W'(b);
                    end
                    else if (b[6:0] > BER_MAX_BYTES)
                    begin
                        res_valid         = 1'b1;
                        res_word.status   = STATUS_BER_LONG;
                        nxt.reported_flag = 1'b1;
                    end
                    else if (b[6:0] == 7'd0)
                    begin
                        len_fire = 1'b1;
                    end
                    else
                    begin
                        nxt.ber_bytes_left     = b[3:0];
                        nxt.length_accumulator = '0;
                        nxt.field_state        = FS_LENN;
                    end
                end
                FS_LENN:
                begin
                    nxt.length_accumulator = acc_shift;
                    nxt.ber_bytes_left     = ber_left_dec;
                    if (ber_left_dec == 4'd0)
                    begin
                        len_fire = 1'b1;
                        len_sel  = acc_shift;
                    end
                end
                FS_SKIP:
                begin
                    nxt.skip_remaining = skip_dec;
                    if (skip_dec == '0)
                    begin
                        nxt.field_state     = FS_KEY;
                        nxt.key_byte_index  = 4'd0;
                        nxt.key_match_flags = 3'b111;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase

            // The length field of the current key is complete.
            if (len_fire)
            begin
                if (cur.search_phase && cur.key_match_flags[FLAG_ESS])
                begin
                    res_valid               = 1'b1;
                    res_word.status         = STATUS_FOUND;
                    res_word.essence_offset = pos_wide[OFS_W-1:0];
                    res_word.essence_length = len_sel;
                    nxt.reported_flag       = 1'b1;
                end
                else if (cur.search_phase && cur.key_match_flags[FLAG_PART])
                begin
                    res_valid         = 1'b1;
                    res_word.status   = STATUS_PARTITION;
                    nxt.reported_flag = 1'b1;
                end
                else
                begin
                    if (!cur.search_phase && cur.key_match_flags[FLAG_BODY])
                        nxt.search_phase = 1'b1;
                    nxt.skip_remaining  = len_sel;
                    nxt.field_state     = (len_sel == '0) ? FS_KEY : FS_SKIP;
                    nxt.key_byte_index  = 4'd0;
                    nxt.key_match_flags = 3'b111;
                end
            end

            nxt_pos = pos_inc;
        end

        // The final byte of a file reports end of stream if nothing was said yet,
        // then rearms the walker for the next file.
        if (in_word.last_byte)
        begin
            if (!res_valid && !cur.reported_flag)
            begin
                res_valid       = 1'b1;
                res_word        = '0;
                res_word.status = STATUS_EOS;
            end
            nxt     = STATE_RESET;
            nxt_pos = '0;
        end
    end

endmodule

FILE: rtl/klv_essence_element_locator_core.sv
// KLV essence element locator.
// The input channel (in_valid, in_stall, in_word) carries one file byte per word,
// from offset zero, with last_byte marking the final byte of the file. The block
// walks the KLV triplets, skips the closed-complete body partition pack and then
// reports the first essence element: its value offset and decoded BER length;
// a partition pack met first is reported instead. At most one result word per
// file leaves on the output channel (out_valid, out_stall, out_word); errors,
// partition packs and end of stream carry zero fields. Throughput is one byte
// per cycle while no result word waits under out_stall: each byte needs one
// pass through the step logic between the input register and the state and
// result registers. A result word is registered when its byte leaves the input
// register and stays on out_valid until the receiver takes it. While a result
// word waits under out_stall, the byte held in the input register waits too
// and in_stall rises; otherwise in_stall stays low. Reset clears all walker
// state, as does a word with last_byte set, so the next byte is taken as offset
// zero of a new file. No result is lost or repeated under stalls on either side.
module klv_essence_element_locator_core
    import klvl_pkg::*;
#(
    parameter int OFFSET_BITS = 48
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  klvl_in_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output klvl_out_t out_word
);

    logic                   in_valid_reg;
    klvl_in_t               in_word_reg;
    klvl_state_t            state_reg;
    klvl_state_t            state_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic                   out_valid_reg;
    klvl_out_t              out_word_reg;
    logic                   res_valid;
    klvl_out_t              res_word;
    logic                   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    klvl_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .cur      (state_reg),
        .cur_pos  (pos_reg),
        .in_word  (in_word_reg),
        .nxt      (state_next),
        .nxt_pos  (pos_next),
        .res_valid(res_valid),
        .res_word (res_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
            end
            if (advance && res_valid)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_word_reg <= in_word;
        if (advance && res_valid)
            out_word_reg <= res_word;
    end

endmodule

FILE: test/klv_essence_element_locator_core_tb.sv
`timescale 1ns / 100ps

module klv_essence_element_locator_core_tb;
    import klvl_pkg::*;

    localparam int ROW_RAW = 0;
    localparam int ROW_KLV = 1;

    localparam int KEY_BODY  = 0;
    localparam int KEY_ESS   = 1;
    localparam int KEY_PART  = 2;
    localparam int KEY_OTHER = 3;
    localparam int KEY_NEAR  = 4;

    localparam int EXP_PRED  = 0;
    localparam int EXP_TYPED = 1;

    localparam int LATENCY      = 2;
    localparam int PHASE_ITEMS  = 170;
    localparam int ESS_BYTES    = 8;
    localparam int PART_BYTES   = 13;
    localparam int BER_LIMIT    = 8;

    localparam logic [127:0] BODY_PACK_KEY   = 128'h060e2b34_02050101_0d010201_01030400;
    localparam logic [63:0]  ESS_KEY_PREFIX  = 64'h060e2b34_01020101;
    localparam logic [103:0] PART_KEY_PREFIX = 104'h060e2b34_02050101_0d010201_01;

    typedef struct {
        int          kind;
        int          key;
        bit          long_form;
        int          ber_n;
        logic [63:0] len;
        logic [7:0]  raw;
        bit          send_val;
        bit          last;
        int          chk;
        klvl_out_t   res;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    klvl_in_t  in_word;
    logic      out_valid;
    logic      out_stall = 1'b0;
    klvl_out_t out_word;

    // Shadow copy of the walker state.
    logic        seek_essence;
    klvl_field_t field;
    logic [3:0]  key_idx;
    logic [2:0]  key_hits;
    logic [6:0]  ber_left;
    logic [63:0] len_acc;
    logic [63:0] skip_left;
    logic [47:0] byte_pos;
    logic        reported;

    klvl_out_t  expected_q[$];
    logic [7:0] file_q[$];
    klvl_out_t  want;
    stim_row_t  directed_rows[$];
    bit         noise_file;
    int         errors = 0;
    int         active_items = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    klv_essence_element_locator_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("klv_essence_element_locator_core regression: fail");
        $finish;
    end

    task automatic walker_rearm();
        seek_essence = 1'b0;
        field        = FS_KEY;
        key_idx      = '0;
        key_hits     = 3'b111;
        ber_left     = '0;
        len_acc      = '0;
        skip_left    = '0;
        byte_pos     = '0;
        reported     = 1'b0;
    endtask

    task automatic length_complete(input logic [63:0] len, output bit hit, output klvl_out_t r);
        hit = 1'b0;
        r   = '0;
        if (seek_essence && (key_hits[FLAG_ESS] || key_hits[FLAG_PART]))
        begin
            hit      = 1'b1;
            reported = 1'b1;
            if (key_hits[FLAG_ESS])
            begin
                r.status         = STATUS_FOUND;
                r.essence_offset = byte_pos + 48'd1;
                r.essence_length = len;
            end
            else
            begin
                r.status = STATUS_PARTITION;
            end
        end
        else
        begin
            if (!seek_essence && key_hits[FLAG_BODY])
                seek_essence = 1'b1;
            skip_left = len;
            field     = (len == 0) ? FS_KEY : FS_SKIP;
            key_idx   = '0;
            key_hits  = 3'b111;
        end
    endtask

    task automatic walker_step(input logic [7:0] b, input logic last, output bit hit,
                               output klvl_out_t r);
        hit = 1'b0;
        r   = '0;
        if (!reported)
        begin
            case (field)
                FS_KEY:
                begin
                    if (b != BODY_PACK_KEY[127 - 8 * key_idx -: 8])
                        key_hits[FLAG_BODY] = 1'b0;
                    if (key_idx < ESS_BYTES && b != ESS_KEY_PREFIX[63 - 8 * key_idx -: 8])
                        key_hits[FLAG_ESS] = 1'b0;
                    if (key_idx < PART_BYTES && b != PART_KEY_PREFIX[103 - 8 * key_idx -: 8])
                        key_hits[FLAG_PART] = 1'b0;
                    if (key_idx == 4'd15)
                    begin
                        key_idx = '0;
                        field   = FS_LEN0;
                    end
                    else
                    begin
                        key_idx = key_idx + 4'd1;
                    end
                end
                FS_LEN0:
                begin
                    if (!b[7])
                    begin
                        length_complete({56'd0, b}, hit, r);
                    end
                    else if (b[6:0] > BER_LIMIT)
                    begin
                        hit      = 1'b1;
                        reported = 1'b1;
                        r.status = STATUS_BER_LONG;
                    end
                    else if (b[6:0] == 7'd0)
                    begin
                        length_complete('0, hit, r);
                    end
                    else
                    begin
                        ber_left = b[6:0];
                        len_acc  = '0;
                        field    = FS_LENN;
                    end
                end
                FS_LENN:
                begin
                    len_acc = {len_acc[55:0], b};
                    if (ber_left != 0)
                        ber_left = ber_left - 7'd1;
                    if (ber_left == 0)
                        length_complete(len_acc, hit, r);
                end
                default:
                begin
                    if (skip_left != 0)
                        skip_left = skip_left - 64'd1;
                    if (skip_left == 0)
                    begin
                        field    = FS_KEY;
                        key_idx  = '0;
                        key_hits = 3'b111;
                    end
                end
            endcase
            byte_pos = byte_pos + 48'd1;
        end
        if (last)
        begin
            if (!hit && !reported)
            begin
                hit      = 1'b1;
                r        = '0;
                r.status = STATUS_EOS;
            end
            walker_rearm();
        end
    endtask

    function automatic stim_row_t klv_row(input int key, input bit long_form, input int ber_n,
                                          input logic [63:0] len, input bit send_val,
                                          input bit last, input int chk = EXP_PRED,
                                          input logic [1:0] st = STATUS_FOUND,
                                          input logic [47:0] ofs = '0,
                                          input logic [63:0] elen = '0);
        stim_row_t row;
        row.kind      = ROW_KLV;
        row.key       = key;
        row.long_form = long_form;
        row.ber_n     = ber_n;
        row.len       = len;
        row.raw       = '0;
        row.send_val  = send_val;
        row.last      = last;
        row.chk       = chk;
        row.res       = '{status: st, essence_offset: ofs, essence_length: elen};
        return row;
    endfunction

    function automatic stim_row_t raw_row(input logic [7:0] b, input bit last,
                                          input int chk = EXP_PRED,
                                          input logic [1:0] st = STATUS_FOUND);
        stim_row_t row;
        row      = klv_row(KEY_OTHER, 1'b0, 0, '0, 1'b0, last, chk, st);
        row.kind = ROW_RAW;
        row.raw  = b;
        return row;
    endfunction

    task automatic push_key(input int key);
        logic [7:0] b;
        int         flip_at;
        flip_at = $urandom_range(0, 15);
        for (int i = 0; i < 16; i++)
        begin
            case (key)
                KEY_BODY:  b = BODY_PACK_KEY[127 - 8 * i -: 8];
                KEY_ESS:   b = (i < ESS_BYTES) ? ESS_KEY_PREFIX[63 - 8 * i -: 8] : 8'($urandom);
                KEY_PART:
                begin
                    if (i < PART_BYTES)
                        b = PART_KEY_PREFIX[103 - 8 * i -: 8];
                    else if (i == PART_BYTES)
                        b = 8'($urandom_range(4, 255));
                    else
                        b = 8'($urandom);
                end
                KEY_NEAR:
                begin
                    b = BODY_PACK_KEY[127 - 8 * i -: 8];
                    if (i == flip_at)
                        b = b ^ 8'($urandom_range(1, 255));
                end
                default:   b = 8'($urandom);
            endcase
            file_q.push_back(b);
        end
    endtask

    task automatic push_length(input bit long_form, input int n, input logic [63:0] len);
        if (!long_form)
        begin
            file_q.push_back(len[7:0]);
        end
        else
        begin
            file_q.push_back({1'b1, 7'(n)});
            if (n <= BER_LIMIT)
                for (int i = n - 1; i >= 0; i--)
                    file_q.push_back(len[8 * i +: 8]);
        end
    endtask

    task automatic push_value(input logic [63:0] len);
        for (longint i = 0; i < len; i++)
            file_q.push_back(8'($urandom));
    endtask

    // Returns once the word has been taken, right after that rising edge.
    task automatic send_word(input logic [7:0] b, input logic last, input bit typed,
                             input klvl_out_t typed_res);
        bit        hit;
        klvl_out_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_word  = '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        active_items++;
        walker_step(b, last, hit, r);
        if (hit)
            expected_q.push_back(typed ? typed_res : r);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic build_random_file();
        int          n_trip;
        int          key;
        int          form;
        int          cut;
        bit          big;
        logic [63:0] len;
        file_q.delete();
        noise_file = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            noise_file = 1'b1;
            repeat ($urandom_range(1, 30))
                file_q.push_back(8'($urandom));
            return;
        end
        n_trip = $urandom_range(1, 4);
        for (int t = 0; t < n_trip; t++)
        begin
            if (t == 0)
                key = ($urandom_range(0, 9) < 7) ? KEY_BODY : $urandom_range(KEY_BODY, KEY_NEAR);
            else
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: key = KEY_ESS;
                    4, 5:       key = KEY_OTHER;
                    6:          key = KEY_BODY;
                    7:          key = KEY_PART;
                    default:    key = KEY_NEAR;
                endcase
            push_key(key);
            form = $urandom_range(0, 19);
            big  = 1'b0;
            if (form < 12)
            begin
                len = 64'($urandom_range(0, (form == 0) ? 127 : 8));
                push_length(1'b0, 0, len);
            end
            else if (form == 12)
            begin
                len = '0;
                push_length(1'b1, 0, len);
            end
            else if (form < 18)
            begin
                big = (form == 17);
                len = big ? {32'($urandom), 32'($urandom)} : 64'($urandom_range(0, 8));
                push_length(1'b1, $urandom_range(1, BER_LIMIT), len);
            end
            else
            begin
                big = 1'b1;
                len = '0;
                push_length(1'b1, $urandom_range(BER_LIMIT + 1, 127), len);
            end
            // A huge length cannot be followed through, so the file ends here.
            if (big)
                break;
            push_value(len);
        end
        if ($urandom_range(0, 6) == 0 && file_q.size() > 1)
        begin
            cut = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > cut)
                void'(file_q.pop_back());
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 6))
                file_q.push_back(8'($urandom));
        end
    endtask

    task automatic run_random(input int items, input int s_idle, input int r_idle);
        int         start;
        logic [7:0] b;
        bit         last;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        start = active_items;
        while (active_items - start < items)
        begin
            build_random_file();
            while (file_q.size() > 0)
            begin
                b    = file_q.pop_front();
                last = (file_q.size() == 0) || (noise_file && $urandom_range(0, 19) == 0);
                send_word(b, last, 1'b0, '0);
            end
        end
    endtask

    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result word with none expected: status %0d offset %0d length %0d",
                         $time, out_word.status, out_word.essence_offset,
                         out_word.essence_length);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_word.status !== want.status
                    || out_word.essence_offset !== want.essence_offset
                    || out_word.essence_length !== want.essence_length)
                begin
                    $display("%0t: expected status %0d offset %0d length %0d, got status %0d offset %0d length %0d",
                             $time, want.status, want.essence_offset, want.essence_length,
                             out_word.status, out_word.essence_offset, out_word.essence_length);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] b;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        walker_rearm();

        directed_rows = '{
            // One-byte files, both byte extremes: the stream ends at once.
            raw_row(8'h00, 1'b1, EXP_TYPED, STATUS_EOS),
            raw_row(8'hff, 1'b1, EXP_TYPED, STATUS_EOS),
            // Empty body pack, then essence found on the final byte.
            klv_row(KEY_BODY, 1'b0, 0, 64'd0, 1'b0, 1'b0),
            klv_row(KEY_ESS, 1'b0, 0, 64'd5, 1'b0, 1'b1, EXP_TYPED, STATUS_FOUND, 48'd34, 64'd5),
            // Long-form 0x80 body pack, then another partition pack.
            klv_row(KEY_OTHER, 1'b0, 0, 64'd3, 1'b1, 1'b0),
            klv_row(KEY_BODY, 1'b1, 0, 64'd0, 1'b0, 1'b0),
            klv_row(KEY_PART, 1'b0, 0, 64'd2, 1'b1, 1'b0, EXP_TYPED, STATUS_PARTITION),
            raw_row(8'h55, 1'b1),
            // Too many length bytes, mid-file and on the final byte.
            klv_row(KEY_OTHER, 1'b1, 9, 64'd0, 1'b0, 1'b0, EXP_TYPED, STATUS_BER_LONG),
            raw_row(8'h00, 1'b1),
            klv_row(KEY_ESS, 1'b1, 127, 64'd0, 1'b0, 1'b1, EXP_TYPED, STATUS_BER_LONG),
            // Largest length that fits in eight bytes.
            klv_row(KEY_BODY, 1'b0, 0, 64'd2, 1'b1, 1'b0),
            klv_row(KEY_ESS, 1'b1, 8, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0),
            raw_row(8'haa, 1'b1),
            // Body pack key again while looking for essence.
            klv_row(KEY_BODY, 1'b0, 0, 64'd1, 1'b1, 1'b0),
            klv_row(KEY_OTHER, 1'b1, 2, 64'd3, 1'b1, 1'b0),
            klv_row(KEY_BODY, 1'b0, 0, 64'd0, 1'b0, 1'b1, EXP_TYPED, STATUS_PARTITION),
            // Essence and partition keys ahead of the body pack are skipped.
            klv_row(KEY_ESS, 1'b0, 0, 64'd4, 1'b1, 1'b0),
            klv_row(KEY_PART, 1'b0, 0, 64'd1, 1'b1, 1'b1, EXP_TYPED, STATUS_EOS),
            // Longest short-form value, then an empty essence element.
            klv_row(KEY_BODY, 1'b0, 0, 64'd127, 1'b1, 1'b0),
            klv_row(KEY_ESS, 1'b1, 1, 64'd0, 1'b0, 1'b0),
            raw_row(8'h12, 1'b1),
            // File cut off inside a key.
            raw_row(8'h06, 1'b0),
            raw_row(8'h0e, 1'b1, EXP_TYPED, STATUS_EOS)
        };

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[k])
        begin
            file_q.delete();
            if (directed_rows[k].kind == ROW_RAW)
            begin
                file_q.push_back(directed_rows[k].raw);
            end
            else
            begin
                push_key(directed_rows[k].key);
                push_length(directed_rows[k].long_form, directed_rows[k].ber_n,
                            directed_rows[k].len);
                if (directed_rows[k].send_val)
                    push_value(directed_rows[k].len);
            end
            while (file_q.size() > 0)
            begin
                b = file_q.pop_front();
                send_word(b, directed_rows[k].last && file_q.size() == 0,
                          directed_rows[k].chk == EXP_TYPED, directed_rows[k].res);
            end
        end
        // Let every result drain before the random part starts.
        hold_until_drained();

        run_random(PHASE_ITEMS, 35, 82);
        hold_until_drained();
        run_random(PHASE_ITEMS, 82, 35);
        run_random(PHASE_ITEMS, 0, 0);

        hold_until_drained();
        repeat (LATENCY + 8)
            @(posedge clk);
        if (errors == 0)
            $display("klv_essence_element_locator_core regression: pass");
        else
            $display("klv_essence_element_locator_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/klvl_pkg.sv
rtl/klvl_step.sv
rtl/klv_essence_element_locator_core.sv
test/klv_essence_element_locator_core_tb.sv
